/* rtl/p1mm_pkg.sv */
// Package for the 1-D max/mean pooling unit: sizes, register indexes, state codes
// and the small clamp and saturation helpers.
// Used by rtl/pool_1d_max_mean_unit.sv. It has no dependencies.
package p1mm_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int MAX_SPAN     = 256;
    localparam int SAMPLE_WIDTH = 16;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int SLOT_W       = $clog2(MAX_SPAN);
    localparam int RS_DEPTH     = MAX_SPAN * MAX_CHANNELS;
    localparam int RS_AW        = SLOT_W + CH_W;
    localparam int ACC_W        = 32;
    localparam int CNT_W        = 16;
    localparam int DVS_W        = CNT_W + 1;
    localparam int DIVC_W       = $clog2(ACC_W);
    localparam int CFG_AW       = 3;
    localparam int CFG_DW       = 7;
    localparam int OUT_DW       = 40;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_GLOBAL_MODE   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_POOL_KIND     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_KERNEL_TAPS   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_WINDOW_STEP   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_TAP_SPACING   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_CHANNEL_COUNT = 3'd5;

    localparam logic KIND_MAX  = 1'b0;
    localparam logic KIND_MEAN = 1'b1;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_ABS   = 13'b0000000000010,
        ST_ABS_G = 13'b0000000000100,
        ST_NEXT  = 13'b0000000001000,
        ST_ROW   = 13'b0000000010000,
        ST_G_RD  = 13'b0000000100000,
        ST_G_LD  = 13'b0000001000000,
        ST_W_RD  = 13'b0000010000000,
        ST_W_ACC = 13'b0000100000000,
        ST_DIV   = 13'b0001000000000,
        ST_DIVQ  = 13'b0010000000000,
        ST_OUT   = 13'b0100000000000,
        ST_FIN   = 13'b1000000000000
    } state_t;

    // Kernel, step and spacing registers: 0 acts as 1, above 16 acts as 16.
    function automatic logic [4:0] clamp_geom(input logic [4:0] v);
        if (v == 5'd0) begin
            return 5'd1;
        end else if (v > 5'd16) begin
            return 5'd16;
        end
        return v;
    endfunction

    function automatic logic [CFG_DW-1:0] clamp_chan(input logic [CFG_DW-1:0] v);
        if (v == '0) begin
            return CFG_DW'(1);
        end else if (v > CFG_DW'(MAX_CHANNELS)) begin
            return CFG_DW'(MAX_CHANNELS);
        end
        return v;
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] sat_signed(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(signed'(32767))) begin
            return 16'h7FFF;
        end else if (v < -ACC_W'(signed'(32768))) begin
            return 16'h8000;
        end
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    // Saturate a quotient given as sign and magnitude.
    function automatic logic [SAMPLE_WIDTH-1:0] sat_mag(input logic neg,
                                                         input logic [ACC_W-1:0] mag);
        logic [ACC_W-1:0] negv;
        negv = '0 - mag;
        if (neg) begin
            if (mag > ACC_W'(32768)) begin
                return 16'h8000;
            end
            return negv[SAMPLE_WIDTH-1:0];
        end
        if (mag > ACC_W'(32767)) begin
            return 16'h7FFF;
        end
        return mag[SAMPLE_WIDTH-1:0];
    endfunction

endpackage

/* rtl/pool_1d_max_mean_unit.sv */
// Top level of the 1-D max/mean pooling unit: sequencer, line store, global
// accumulators and a shared bit-serial divider.
// Depends on rtl/p1mm_pkg.sv.
//
// Channel   Dir  Beat contents
// s_        in   tdata[15:0] sample (Q8.8); tlast end of sequence
// m_        out  tdata[15:0] pooled, [21:16] channel, [37:22] out_row; tlast last
// cfg_      in   write enable, register index, write data (no read-back)
//
// A sample passes IDLE, ABS (and ABS_G in global mode) and NEXT; one that closes a row adds ROW and FIN.
// A row that completes a window, per channel, reads each tap through the line store read
// port (W_RD, W_ACC) and emits one result beat; the mean adds a divider pass (DIV, DIVQ).
// A global result reads each channel's accumulator (G_RD, G_LD), then divides it for the mean.
// aresetn is synchronous; the line store is not cleared and accumulators use valid bits.
// The output register waits for m_tready; the sequencer stalls until it frees.
module pool_1d_max_mean_unit
    import p1mm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] sample
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_DW-1:0]   m_tdata,   // [15:0] pooled, [21:16] channel, [37:22] out_row
    output logic                m_tlast,
    input  logic                cfg_wr_en,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wr_data
);

    state_t state_reg, state_next;

    logic              glob_reg, kind_reg;
    logic [4:0]        taps_cfg_reg, step_cfg_reg, sp_cfg_reg;
    logic [CFG_DW-1:0] chan_cfg_reg;

    logic [CH_W-1:0]   ch_cnt_reg, ch_cnt_next;
    logic [CNT_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [CNT_W-1:0]  orow_reg, orow_next;
    logic [SLOT_W-1:0] ring_reg, ring_next;
    logic [SLOT_W-1:0] due_reg, due_next;
    logic              eos_reg, eos_next;
    logic [SAMPLE_WIDTH-1:0] abs_val_reg, abs_val_next;
    logic [CH_W-1:0]   emit_ch_reg, emit_ch_next;
    logic [3:0]        tap_k_reg, tap_k_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [DVS_W-1:0]  div_rem_reg, div_rem_next;
    logic [DVS_W-1:0]  div_dvs_reg, div_dvs_next;
    logic [ACC_W-1:0]  div_quo_reg, div_quo_next;
    logic [DIVC_W-1:0] div_cnt_reg, div_cnt_next;
    logic              div_neg_reg, div_neg_next;
    logic [SAMPLE_WIDTH-1:0] res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_DW-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic [MAX_CHANNELS-1:0] acc_vld_reg, acc_vld_next;

    // Memories and their registered read data.
    logic [SAMPLE_WIDTH-1:0] row_mem [0:RS_DEPTH-1];
    logic [ACC_W-1:0]        acc_mem [0:MAX_CHANNELS-1];
    logic [SAMPLE_WIDTH-1:0] rs_rdata_reg;
    logic [ACC_W-1:0]        acc_rdata_reg;
    logic                    acc_rvld_reg;

    logic              rs_we, acc_we;
    logic [ACC_W-1:0]  acc_wdata;
    logic [RS_AW-1:0]  rs_waddr, rs_raddr;
    logic [CH_W-1:0]   acc_addr;

    logic [4:0]        taps_eff, step_eff, sp_eff;
    logic [CFG_DW-1:0] cc_eff;
    logic [3:0]        tap_dist;
    logic [8:0]        tap_back, span_full;
    logic [SLOT_W-1:0] tap_slot, due_eff;
    logic              last_ch;

    logic signed [ACC_W-1:0] acc_old, sample_x, sample_v, g_new, w_new;
    logic signed [ACC_W:0]   g_sum;
    logic [DVS_W:0]          div_trial;

    assign taps_eff = clamp_geom(taps_cfg_reg);
    assign step_eff = clamp_geom(step_cfg_reg);
    assign sp_eff   = clamp_geom(sp_cfg_reg);
    assign cc_eff   = clamp_chan(chan_cfg_reg);

    // Ring slot of the current tap: taps later in the window are closer to now.
    assign tap_dist  = 4'(taps_eff - 5'd1 - {1'b0, tap_k_reg});
    assign tap_back  = tap_dist * sp_eff;
    assign tap_slot  = ring_reg - tap_back[SLOT_W-1:0];
    assign span_full = 4'(taps_eff - 5'd1) * sp_eff;
    assign due_eff   = (row_cnt_reg == '0) ? span_full[SLOT_W-1:0] : due_reg;

    assign rs_waddr = {ring_reg, ch_cnt_reg};
    assign rs_raddr = {tap_slot, emit_ch_reg};
    assign acc_addr = (state_reg == ST_G_RD) ? emit_ch_reg : ch_cnt_reg;
    assign last_ch  = ({1'b0, emit_ch_reg} + CFG_DW'(1)) == cc_eff;

    assign acc_old  = acc_rvld_reg ? signed'(acc_rdata_reg) : '0;
    assign sample_v = ACC_W'(signed'(abs_val_reg));
    assign sample_x = ACC_W'(signed'(rs_rdata_reg));
    assign g_sum    = (ACC_W + 1)'(acc_old) + (ACC_W + 1)'(sample_v);

    always_comb begin
        if (row_cnt_reg == '0) begin
            g_new = sample_v;
        end else if (kind_reg == KIND_MAX) begin
            g_new = (sample_v > acc_old) ? sample_v : acc_old;
        end else if (g_sum > (ACC_W + 1)'(signed'(2147483647))) begin
            g_new = 32'sh7FFFFFFF;
        end else if (g_sum < -(ACC_W + 1)'(signed'(33'sd2147483648))) begin
            g_new = 32'sh80000000;
        end else begin
            g_new = g_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        if (tap_k_reg == '0) begin
            w_new = sample_x;
        end else if (kind_reg == KIND_MAX) begin
            w_new = (sample_x > acc_reg) ? sample_x : acc_reg;
        end else begin
            w_new = acc_reg + sample_x;
        end
    end

    assign div_trial = {div_rem_reg, div_quo_reg[ACC_W-1]};
    assign acc_wdata = g_new;

    always_comb begin
        state_next   = state_reg;
        ch_cnt_next  = ch_cnt_reg;
        row_cnt_next = row_cnt_reg;
        orow_next    = orow_reg;
        ring_next    = ring_reg;
        due_next     = due_reg;
        eos_next     = eos_reg;
        abs_val_next = abs_val_reg;
        emit_ch_next = emit_ch_reg;
        tap_k_next   = tap_k_reg;
        acc_next     = acc_reg;
        div_rem_next = div_rem_reg;
        div_dvs_next = div_dvs_reg;
        div_quo_next = div_quo_reg;
        div_cnt_next = div_cnt_reg;
        div_neg_next = div_neg_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        acc_vld_next = acc_vld_reg;
        m_valid_next = m_valid_reg && !m_tready;
        rs_we        = 1'b0;
        acc_we       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    abs_val_next = s_tdata;
                    eos_next     = s_tlast;
                    state_next   = ST_ABS;
                end
            end
            ST_ABS: begin
                if (glob_reg) begin
                    state_next = ST_ABS_G;
                end else begin
                    rs_we      = 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_ABS_G: begin
                acc_we                   = 1'b1;
                acc_vld_next[ch_cnt_reg] = 1'b1;
                state_next               = ST_NEXT;
            end
            ST_NEXT: begin
                // A sequence that ends mid-row is padded with zero samples.
                if (({1'b0, ch_cnt_reg} + CFG_DW'(1)) < cc_eff) begin
                    ch_cnt_next = ch_cnt_reg + CH_W'(1);
                    if (eos_reg) begin
                        abs_val_next = '0;
                        state_next   = ST_ABS;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW: begin
                emit_ch_next = '0;
                tap_k_next   = '0;
                if (glob_reg) begin
                    state_next = eos_reg ? ST_G_RD : ST_FIN;
                end else if (due_eff == '0) begin
                    state_next = ST_W_RD;
                end else begin
                    due_next   = due_eff - SLOT_W'(1);
                    state_next = ST_FIN;
                end
            end
            ST_G_RD: begin
                state_next = ST_G_LD;
            end
            ST_G_LD: begin
                acc_next = acc_old;
                if (kind_reg == KIND_MEAN) begin
                    div_neg_next = acc_old[ACC_W-1];
                    div_quo_next = acc_old[ACC_W-1] ? ('0 - acc_old) : acc_old;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    div_dvs_next = DVS_W'(row_cnt_reg) + DVS_W'(1);
                    state_next   = ST_DIV;
                end else begin
                    res_next   = sat_signed(acc_old);
                    state_next = ST_OUT;
                end
            end
            ST_W_RD: begin
                state_next = ST_W_ACC;
            end
            ST_W_ACC: begin
                acc_next = w_new;
                if ({1'b0, tap_k_reg} == (taps_eff - 5'd1)) begin
                    if (kind_reg == KIND_MEAN) begin
                        div_neg_next = w_new[ACC_W-1];
                        div_quo_next = w_new[ACC_W-1] ? ('0 - w_new) : w_new;
                        div_rem_next = '0;
                        div_cnt_next = '0;
                        div_dvs_next = DVS_W'(taps_eff);
                        state_next   = ST_DIV;
                    end else begin
                        res_next   = sat_signed(w_new);
                        state_next = ST_OUT;
                    end
                end else begin
                    tap_k_next = tap_k_reg + 4'd1;
                    state_next = ST_W_RD;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (div_trial >= {1'b0, div_dvs_reg}) begin
                    div_rem_next = DVS_W'(div_trial - {1'b0, div_dvs_reg});
                    div_quo_next = {div_quo_reg[ACC_W-2:0], 1'b1};
                end else begin
                    div_rem_next = div_trial[DVS_W-1:0];
                    div_quo_next = {div_quo_reg[ACC_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DIVC_W'(1);
                if (div_cnt_reg == DIVC_W'(ACC_W - 1)) begin
                    state_next = ST_DIVQ;
                end
            end
            ST_DIVQ: begin
                res_next   = sat_mag(div_neg_reg, div_quo_reg);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, (glob_reg ? CNT_W'(0) : orow_reg), emit_ch_reg,
                                    res_reg};
                    m_last_next  = last_ch && (glob_reg || eos_reg);
                    if (last_ch) begin
                        if (!glob_reg) begin
                            orow_next = orow_reg + CNT_W'(1);
                            due_next  = SLOT_W'(step_eff - 5'd1);
                        end
                        state_next = ST_FIN;
                    end else begin
                        emit_ch_next = emit_ch_reg + CH_W'(1);
                        tap_k_next   = '0;
                        state_next   = glob_reg ? ST_G_RD : ST_W_RD;
                    end
                end
            end
            ST_FIN: begin
                ch_cnt_next = '0;
                if (eos_reg) begin
                    row_cnt_next = '0;
                    ring_next    = '0;
                    orow_next    = '0;
                    due_next     = '0;
                end else begin
                    ring_next = ring_reg + SLOT_W'(1);
                    if (row_cnt_reg != '1) begin
                        row_cnt_next = row_cnt_reg + CNT_W'(1);
                    end
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ch_cnt_reg   <= '0;
            row_cnt_reg  <= '0;
            orow_reg     <= '0;
            ring_reg     <= '0;
            due_reg      <= '0;
            eos_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            acc_vld_reg  <= '0;
            glob_reg     <= 1'b0;
            kind_reg     <= KIND_MAX;
            taps_cfg_reg <= 5'd1;
            step_cfg_reg <= 5'd1;
            sp_cfg_reg   <= 5'd1;
            chan_cfg_reg <= CFG_DW'(1);
        end else begin
            state_reg    <= state_next;
            ch_cnt_reg   <= ch_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            orow_reg     <= orow_next;
            ring_reg     <= ring_next;
            due_reg      <= due_next;
            eos_reg      <= eos_next;
            m_valid_reg  <= m_valid_next;
            acc_vld_reg  <= acc_vld_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_GLOBAL_MODE:   glob_reg     <= cfg_wr_data[0];
                    REG_POOL_KIND:     kind_reg     <= cfg_wr_data[0];
                    REG_KERNEL_TAPS:   taps_cfg_reg <= cfg_wr_data[4:0];
                    REG_WINDOW_STEP:   step_cfg_reg <= cfg_wr_data[4:0];
                    REG_TAP_SPACING:   sp_cfg_reg   <= cfg_wr_data[4:0];
                    REG_CHANNEL_COUNT: chan_cfg_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        abs_val_reg  <= abs_val_next;
        emit_ch_reg  <= emit_ch_next;
        tap_k_reg    <= tap_k_next;
        acc_reg      <= acc_next;
        div_rem_reg  <= div_rem_next;
        div_dvs_reg  <= div_dvs_next;
        div_quo_reg  <= div_quo_next;
        div_cnt_reg  <= div_cnt_next;
        div_neg_reg  <= div_neg_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        acc_rvld_reg <= acc_vld_reg[acc_addr];
    end

    always_ff @(posedge aclk) begin
        if (rs_we) begin
            row_mem[rs_waddr] <= abs_val_reg;
        end
        rs_rdata_reg <= row_mem[rs_raddr];
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_addr] <= acc_wdata;
        end
        acc_rdata_reg <= acc_mem[acc_addr];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/p1mm_checker.sv */
// Port-level checker for the 1-D max/mean pooling unit, bound to the top level.
// Depends on rtl/p1mm_pkg.sv and rtl/pool_1d_max_mean_unit.sv.
module p1mm_checker
    import p1mm_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_DW-1:0] m_tdata,
    input logic              m_tlast
);

    // A held result beat keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Each accepted sample occupies the sequencer, so inputs are never accepted back to back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // Reset leaves the block ready for input and with no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("state after reset is wrong");

    // Results are only produced while an item is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !s_tready)
        else $error("result produced while idle");

endmodule

bind pool_1d_max_mean_unit p1mm_checker u_p1mm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* tb/tb_top.sv */
// Self-checking testbench for pool_1d_max_mean_unit: a directed table, then random
// sequences in window and global mode, checked beat by beat against a local predictor.
// Depends on rtl/p1mm_pkg.sv and rtl/pool_1d_max_mean_unit.sv.
module tb_top;
    import p1mm_pkg::*;

    localparam int IDLE_PCT    = 12;
    localparam int SETTLE_CYC  = 4500;
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_ITEMS  = 360;

    typedef struct {
        logic [15:0] pooled;
        logic [5:0]  chan;
        logic [15:0] orow;
        logic        last;
    } pooled_t;

    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic [CFG_AW-1:0]   addr;
        logic [CFG_DW-1:0]   value;
        logic [15:0]         smp;
        logic                eos;
        int                  exp_n;    // -1 when only the predictor checks this beat
        logic [15:0]         exp_val;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_DW-1:0]   m_tdata;
    logic                m_tlast;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr = '0;
    logic [CFG_DW-1:0]   cfg_wr_data = '0;

    pool_1d_max_mean_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state, a mirror of the block's registers and line store.
    int          ring [MAX_SPAN][MAX_CHANNELS];
    longint      gacc [MAX_CHANNELS];
    int unsigned ch_ctr, row_ctr, orow_ctr, slot, due;
    int unsigned r_gmode, r_kind, r_taps, r_step, r_spacing, r_chans;

    pooled_t     pooled_q[$];
    int          last_n;
    logic [15:0] last_pooled;
    int          errors = 0;
    int          mismatches = 0;
    int          stall_cnt = 0;
    bit          s_took = 1'b0;
    bit          idle_on = 1'b1;
    int          rand_items = 0;
    bit          beats_since_drain = 1'b0;

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [15:0] sat16(longint v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    task automatic absorb(int unsigned c, int v);
        longint a;
        c = c % MAX_CHANNELS;
        if (r_gmode != 0) begin
            a = gacc[c];
            if (row_ctr == 0) begin
                a = v;
            end else if (r_kind == KIND_MAX) begin
                a = (v > a) ? v : a;
            end else begin
                a += v;
                if (a > 64'sd2147483647) a = 64'sd2147483647;
                if (a < -64'sd2147483648) a = -64'sd2147483648;
            end
            gacc[c] = a;
        end else begin
            ring[slot][c] = v;
        end
    endtask

    function automatic logic [15:0] window_value(int unsigned ch);
        int unsigned taps, sp, back, s;
        longint acc, x;
        taps = clip(r_taps, 1, 16);
        sp = clip(r_spacing, 1, 16);
        acc = 0;
        for (int unsigned k = 0; k < taps; k++) begin
            back = ((taps - 1 - k) * sp) % MAX_SPAN;
            s = (slot + MAX_SPAN - back) % MAX_SPAN;
            x = ring[s][ch % MAX_CHANNELS];
            if (k == 0) acc = x;
            else if (r_kind == KIND_MAX) acc = (x > acc) ? x : acc;
            else acc += x;
        end
        if (r_kind == KIND_MEAN) acc = acc / longint'(taps);
        return sat16(acc);
    endfunction

    task automatic add_result(logic [15:0] val, int unsigned ch, int unsigned orow, bit lst);
        pooled_t r;
        r.pooled = val;
        r.chan = ch[5:0];
        r.orow = orow[15:0];
        r.last = lst;
        pooled_q.insert(pooled_q.size(), r);
        last_n++;
        last_pooled = val;
    endtask

    task automatic predict_beat(logic [15:0] raw, logic eos);
        int unsigned cc;
        longint a;
        cc = clip(r_chans, 1, MAX_CHANNELS);
        last_n = 0;
        absorb(ch_ctr, int'(signed'(raw)));
        if (!eos && ch_ctr + 1 < cc) begin
            ch_ctr++;
            return;
        end
        // A sequence that ends mid-row fills the missing channels with zeros.
        if (eos) begin
            for (int unsigned ch = ch_ctr + 1; ch < cc; ch++) absorb(ch, 0);
        end
        if (r_gmode != 0) begin
            if (eos) begin
                for (int unsigned ch = 0; ch < cc; ch++) begin
                    a = gacc[ch];
                    if (r_kind == KIND_MEAN) a = a / (longint'(row_ctr) + 1);
                    add_result(sat16(a), ch, 0, ch + 1 == cc);
                end
            end
        end else begin
            if (row_ctr == 0) due = (clip(r_taps, 1, 16) - 1) * clip(r_spacing, 1, 16);
            if (due == 0) begin
                for (int unsigned ch = 0; ch < cc; ch++) begin
                    add_result(window_value(ch), ch, orow_ctr, eos && ch + 1 == cc);
                end
                orow_ctr = (orow_ctr + 1) & 16'hFFFF;
                due = clip(r_step, 1, 16) - 1;
            end else begin
                due--;
            end
        end
        slot = (slot + 1) % MAX_SPAN;
        if (row_ctr < 16'hFFFF) row_ctr++;
        ch_ctr = 0;
        if (eos) begin
            row_ctr = 0;
            slot = 0;
            orow_ctr = 0;
            due = 0;
        end
    endtask

    task automatic report(string what, longint expv, longint actv);
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH %s: expected %0h, got %0h", what, expv, actv);
    endtask

    // Both handshakes are observed here, at the rising edge.
    always @(posedge aclk) begin
        pooled_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_beat(s_tdata, s_tlast);
                s_took = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (pooled_q.size() == 0) begin
                    report("unexpected result beat", 0, m_tdata[15:0]);
                end else begin
                    e = pooled_q.pop_front();
                    if (m_tdata[15:0] !== e.pooled) report("pooled", e.pooled, m_tdata[15:0]);
                    if (m_tdata[21:16] !== e.chan) report("channel", e.chan, m_tdata[21:16]);
                    if (m_tdata[37:22] !== e.orow) report("out_row", e.orow, m_tdata[37:22]);
                    if (m_tlast !== e.last) report("last", e.last, m_tlast);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cnt = 0;
            end else begin
                stall_cnt++;
                if (stall_cnt >= STALL_LIMIT) begin
                    $display("tb_top failed");
                    $finish;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_tready = !aresetn ? 1'b0 : (!idle_on || $urandom_range(99) >= IDLE_PCT);
    end

    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wr_data = value;
        case (addr)
            REG_GLOBAL_MODE:   r_gmode = value & 1;
            REG_POOL_KIND:     r_kind = value & 1;
            REG_KERNEL_TAPS:   r_taps = value & 5'h1F;
            REG_WINDOW_STEP:   r_step = value & 5'h1F;
            REG_TAP_SPACING:   r_spacing = value & 5'h1F;
            REG_CHANNEL_COUNT: r_chans = value & 7'h7F;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Hold the sender until every expected result is out and the block has settled.
    task automatic drain();
        while (pooled_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
        beats_since_drain = 1'b0;
    endtask

    task automatic push_beat(logic [15:0] smp, logic eos);
        while (idle_on && $urandom_range(99) < IDLE_PCT) @(negedge aclk);
        s_tdata = smp;
        s_tlast = eos;
        s_tvalid = 1'b1;
        s_took = 1'b0;
        do @(negedge aclk); while (!s_took);
        s_tvalid = 1'b0;
        beats_since_drain = 1'b1;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    stim_row_t table_rows[$];

    task automatic add_cfg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] value);
        table_rows.insert(table_rows.size(), '{ROW_CFG, addr, value, 16'h0, 1'b0, -1, 16'h0});
    endtask

    task automatic add_beat(logic [15:0] smp, logic eos, int exp_n, logic [15:0] exp_val);
        table_rows.insert(table_rows.size(),
                          '{ROW_BEAT, REG_GLOBAL_MODE, '0, smp, eos, exp_n, exp_val});
    endtask

    initial begin
        int unsigned span, rows, cc, cut;
        r_gmode = 0; r_kind = 0; r_taps = 1; r_step = 1; r_spacing = 1; r_chans = 1;
        ch_ctr = 0; row_ctr = 0; orow_ctr = 0; slot = 0; due = 0;
        foreach (gacc[i]) gacc[i] = 0;

        // After reset every sample is its own one-tap window.
        add_beat(16'h7FFF, 1'b0, 1, 16'h7FFF);
        add_beat(16'h8000, 1'b0, 1, 16'h8000);
        add_beat(16'h0001, 1'b0, 1, 16'h0001);
        add_beat(16'hFFFF, 1'b1, 1, 16'hFFFF);
        // Two-tap mean over two channels, ended by a partial row.
        add_cfg(REG_POOL_KIND, CFG_DW'(KIND_MEAN));
        add_cfg(REG_KERNEL_TAPS, 7'd2);
        add_cfg(REG_CHANNEL_COUNT, 7'd2);
        add_beat(16'hFFFD, 1'b0, 0, 16'h0);
        add_beat(16'h0002, 1'b0, -1, 16'h0);
        add_beat(16'h7FFF, 1'b1, -1, 16'h0);
        // A sequence shorter than one window gives nothing.
        add_beat(16'h1234, 1'b1, 0, 16'h0);
        // Global max, with a zero channel count acting as one.
        add_cfg(REG_GLOBAL_MODE, 7'd1);
        add_cfg(REG_POOL_KIND, CFG_DW'(KIND_MAX));
        add_cfg(REG_CHANNEL_COUNT, 7'd0);
        add_beat(16'h0005, 1'b0, 0, 16'h0);
        add_beat(16'h8000, 1'b0, 0, 16'h0);
        add_beat(16'h7FFF, 1'b1, 1, 16'h7FFF);
        add_cfg(REG_POOL_KIND, CFG_DW'(KIND_MEAN));
        add_beat(16'h7FFF, 1'b0, 0, 16'h0);
        add_beat(16'h7FFF, 1'b0, 0, 16'h0);
        add_beat(16'h0001, 1'b1, 1, 16'h5555);
        add_beat(16'h8000, 1'b0, 0, 16'h0);
        add_beat(16'h8000, 1'b1, 1, 16'h8000);

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        foreach (table_rows[i]) begin
            if (table_rows[i].kind == ROW_CFG) begin
                if (beats_since_drain) drain();
                write_reg(table_rows[i].addr, table_rows[i].value);
            end else begin
                push_beat(table_rows[i].smp, table_rows[i].eos);
                if (table_rows[i].exp_n >= 0 &&
                    (last_n != table_rows[i].exp_n ||
                     (last_n == 1 && last_pooled !== table_rows[i].exp_val))) begin
                    report("directed beat", table_rows[i].exp_val, last_pooled);
                end
            end
        end

        for (int phase = 0; rand_items < RAND_ITEMS; phase++) begin
            drain();
            if (phase == 0) begin
                // Widest window: sixteen taps sixteen rows apart, out-of-range writes.
                write_reg(REG_GLOBAL_MODE, 7'd0);
                write_reg(REG_POOL_KIND, 7'($urandom_range(1)));
                write_reg(REG_KERNEL_TAPS, 7'd31);
                write_reg(REG_WINDOW_STEP, 7'd16);
                write_reg(REG_TAP_SPACING, 7'd31);
                write_reg(REG_CHANNEL_COUNT, 7'd1);
            end else if (phase == 1) begin
                write_reg(REG_GLOBAL_MODE, 7'd1);
                write_reg(REG_POOL_KIND, 7'($urandom_range(1)));
                write_reg(REG_KERNEL_TAPS, 7'd0);
                write_reg(REG_WINDOW_STEP, 7'd0);
                write_reg(REG_TAP_SPACING, 7'd0);
                write_reg(REG_CHANNEL_COUNT, 7'd127);
            end else begin
                write_reg(REG_GLOBAL_MODE, 7'($urandom_range(1)));
                write_reg(REG_POOL_KIND, 7'($urandom_range(1)));
                write_reg(REG_KERNEL_TAPS, 7'($urandom_range(5)));
                write_reg(REG_WINDOW_STEP, 7'($urandom_range(31)));
                write_reg(REG_TAP_SPACING, 7'($urandom_range(3)));
                write_reg(REG_CHANNEL_COUNT,
                          ($urandom_range(9) == 0) ? 7'd64 : 7'($urandom_range(4)));
                if (r_step > 6 && $urandom_range(1)) write_reg(REG_WINDOW_STEP, 7'd1);
                // Wide rows in window mode use one tap to keep the run short.
                if (clip(r_chans, 1, MAX_CHANNELS) > 8 && r_gmode == 0) begin
                    write_reg(REG_KERNEL_TAPS, 7'd1);
                end
            end
            cc = clip(r_chans, 1, MAX_CHANNELS);
            span = (clip(r_taps, 1, 16) - 1) * clip(r_spacing, 1, 16);
            for (int sq = 0; sq < ((phase < 2) ? 1 : 3) && rand_items < RAND_ITEMS; sq++) begin
                if (r_gmode != 0) rows = (cc > 8) ? 1 : $urandom_range(1, 6);
                else if (span > 0 && $urandom_range(9) == 0) rows = $urandom_range(1, span);
                else rows = span + 1 + ((phase == 0) ? 4 : $urandom_range(5));
                if (cc > 8) rows = (rows > span + 2) ? span + 2 : rows;
                cut = ($urandom_range(3) == 0) ? $urandom_range(1, cc) : cc;
                for (int r = 0; r < rows; r++) begin
                    for (int c = 0; c < ((r + 1 == rows) ? cut : cc); c++) begin
                        idle_on = !(rand_items >= 100 && rand_items < 200);
                        push_beat(rand_sample(), r + 1 == rows && c + 1 == cut);
                        rand_items++;
                    end
                end
            end
        end

        idle_on = 1'b1;
        drain();
        errors += pooled_q.size();
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
